// File: sv/ssoc_pkg.sv
// shared constants for the shell sort block with operation counts
// no dependencies; imported by shell_sort_with_op_counts
package ssoc_pkg;

  localparam int unsigned MAX_ITEMS_DEF = 64;  // default store depth
  localparam int unsigned DATA_W        = 32;  // element width
  localparam int unsigned OPCNT_W       = 16;  // width of the saturating op counters

endpackage

// File: sv/shell_sort_with_op_counts.sv
// schedule: after the beat marked last, each gap visits every position from gap to n-1,
// and each position reads its element, compares it down its chain and writes it back,
// all bound by the single read port of the element store;
// each sorted beat is then read, loaded into the output register and held until accepted.
// loading accepts one beat per cycle; no input is taken while a set sorts or drains.
// reset (rst_ni low, async) clears the state machine, the fill count, both op counters
// and the output valid; the element store holds no reset and is written before read.
// shell sort with operation counts: top level, store, sequencer and output register
// depends on ssoc_pkg
module shell_sort_with_op_counts #(
  parameter int unsigned MAX_ITEMS = ssoc_pkg::MAX_ITEMS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [ssoc_pkg::DATA_W-1:0]  value_i,
  input  logic                                last_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [ssoc_pkg::DATA_W-1:0]  sorted_value_o,
  output logic                                last_res_o,
  output logic        [ssoc_pkg::OPCNT_W-1:0] comparisons_o,
  output logic        [ssoc_pkg::OPCNT_W-1:0] shifts_o
);
  import ssoc_pkg::*;

  localparam int unsigned AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int unsigned CW = $clog2(MAX_ITEMS + 1);
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ITEMS);

  typedef enum logic [2:0] {
    S_LOAD,
    S_RD_HELD,
    S_WAIT_HELD,
    S_CHECK,
    S_CMP,
    S_OUT_RD,
    S_OUT_LD,
    S_OUT_WAIT
  } state_e;

  // element store, one write and one registered read per cycle
  logic [DATA_W-1:0] store_q [MAX_ITEMS];
  logic [DATA_W-1:0] rd_q;
  logic              we;
  logic [AW-1:0]     waddr;
  logic [DATA_W-1:0] wdata;
  logic [AW-1:0]     raddr;

  state_e              state_q, state_d;
  logic [CW-1:0]       cnt_q, cnt_d;
  logic [CW-1:0]       gap_q, gap_d;
  logic [CW-1:0]       pos_q, pos_d;
  logic [CW-1:0]       walk_q, walk_d;
  logic [DATA_W-1:0]   held_q, held_d;
  logic [OPCNT_W-1:0]  cmp_q, cmp_d;
  logic [OPCNT_W-1:0]  shf_q, shf_d;
  logic                out_valid_q, out_valid_d;
  logic [DATA_W-1:0]   out_val_q, out_val_d;
  logic                out_last_q, out_last_d;

  logic [CW-1:0] cnt_inc;
  logic [CW-1:0] pos_inc;
  logic [CW-1:0] gap_half;
  logic [CW-1:0] walk_back;
  logic          is_less;

  always_ff @(posedge clk_i) begin
    if (we) begin
      store_q[waddr] <= wdata;
    end
    rd_q <= store_q[raddr];
  end

  assign cnt_inc   = (cnt_q < MAX_CNT) ? cnt_q + CW'(1) : cnt_q;
  assign pos_inc   = pos_q + CW'(1);
  assign gap_half  = gap_q >> 1;
  assign walk_back = walk_q - gap_q;
  assign is_less   = $signed(held_q) < $signed(rd_q);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    gap_d       = gap_q;
    pos_d       = pos_q;
    walk_d      = walk_q;
    held_d      = held_q;
    cmp_d       = cmp_q;
    shf_d       = shf_q;
    out_valid_d = out_valid_q;
    out_val_d   = out_val_q;
    out_last_d  = out_last_q;
    we          = 1'b0;
    waddr       = walk_q[AW-1:0];
    wdata       = held_q;
    raddr       = pos_q[AW-1:0];

    unique case (state_q) inside
      S_LOAD: begin
        if (in_valid_i) begin
          // beats past a full store are dropped
          if (cnt_q < MAX_CNT) begin
            we    = 1'b1;
            waddr = cnt_q[AW-1:0];
            wdata = value_i;
          end
          cnt_d = cnt_inc;
          if (last_i) begin
            cmp_d = '0;
            shf_d = '0;
            gap_d = cnt_inc >> 1;
            if ((cnt_inc >> 1) == '0) begin
              pos_d   = '0;
              state_d = S_OUT_RD;
            end else begin
              pos_d   = cnt_inc >> 1;
              state_d = S_RD_HELD;
            end
          end
        end
      end
      S_RD_HELD: begin
        raddr   = pos_q[AW-1:0];
        state_d = S_WAIT_HELD;
      end
      S_WAIT_HELD: begin
        held_d  = rd_q;
        walk_d  = pos_q;
        state_d = S_CHECK;
      end
      S_CHECK, S_CMP: begin
        if (state_q == S_CHECK && walk_q >= gap_q) begin
          raddr   = walk_back[AW-1:0];
          state_d = S_CMP;
        end else if (state_q == S_CMP && is_less) begin
          // move the larger element up by one gap
          if (cmp_q != '1) cmp_d = cmp_q + OPCNT_W'(1);
          if (shf_q != '1) shf_d = shf_q + OPCNT_W'(1);
          we      = 1'b1;
          waddr   = walk_q[AW-1:0];
          wdata   = rd_q;
          walk_d  = walk_back;
          state_d = S_CHECK;
        end else begin
          if (state_q == S_CMP && cmp_q != '1) cmp_d = cmp_q + OPCNT_W'(1);
          // drop the held element in place, then next position, next gap or the output phase
          we    = 1'b1;
          waddr = walk_q[AW-1:0];
          wdata = held_q;
          if (pos_inc != cnt_q) begin
            pos_d   = pos_inc;
            state_d = S_RD_HELD;
          end else begin
            gap_d = gap_half;
            if (gap_half == '0) begin
              pos_d   = '0;
              state_d = S_OUT_RD;
            end else begin
              pos_d   = gap_half;
              state_d = S_RD_HELD;
            end
          end
        end
      end
      S_OUT_RD: begin
        raddr   = pos_q[AW-1:0];
        state_d = S_OUT_LD;
      end
      S_OUT_LD: begin
        out_valid_d = 1'b1;
        out_val_d   = rd_q;
        out_last_d  = (pos_inc == cnt_q);
        state_d     = S_OUT_WAIT;
      end
      S_OUT_WAIT: begin
        if (out_ready_i) begin
          out_valid_d = 1'b0;
          pos_d       = pos_inc;
          if (out_last_q) begin
            cnt_d   = '0;
            cmp_d   = '0;
            shf_d   = '0;
            state_d = S_LOAD;
          end else begin
            state_d = S_OUT_RD;
          end
        end
      end
      default: state_d = S_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_LOAD;
      cnt_q       <= '0;
      gap_q       <= '0;
      pos_q       <= '0;
      walk_q      <= '0;
      cmp_q       <= '0;
      shf_q       <= '0;
      out_valid_q <= 1'b0;
      out_last_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      gap_q       <= gap_d;
      pos_q       <= pos_d;
      walk_q      <= walk_d;
      cmp_q       <= cmp_d;
      shf_q       <= shf_d;
      out_valid_q <= out_valid_d;
      out_last_q  <= out_last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    held_q    <= held_d;
    out_val_q <= out_val_d;
  end

  assign in_ready_o     = (state_q == S_LOAD);
  assign out_valid_o    = out_valid_q;
  assign sorted_value_o = out_val_q;
  assign last_res_o     = out_last_q;
  assign comparisons_o  = cmp_q;
  assign shifts_o       = shf_q;

endmodule
